// ----- design/b64enc_pkg.sv -----
`default_nettype none

package b64enc_pkg;

	// Register reset and line length floor
	localparam logic [7:0] LINE_CHARS_RESET = 8'd72;
	localparam logic [7:0] MIN_LINE         = 8'd4;

	// Character codes
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_PAD     = 8'h3D;
	localparam logic [7:0] CHAR_LF      = 8'h0A;

	// Sextet ranges of the alphabet
	localparam logic [5:0] SEXTET_LOWER = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT = 6'd52;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;

	// Position of the next byte in its three-byte group
	typedef enum logic [1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2
	} phase_t;

	// Characters produced by one input byte
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            msg_end;
	} group_t;

	// Map a sextet to its base64 character
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < SEXTET_LOWER) begin
			return CHAR_UPPER_A + w;
		end else if (v < SEXTET_DIGIT) begin
			return CHAR_LOWER_A + w - {2'b00, SEXTET_LOWER};
		end else if (v < SEXTET_PLUS) begin
			return CHAR_ZERO + w - {2'b00, SEXTET_DIGIT};
		end else if (v == SEXTET_PLUS) begin
			return CHAR_PLUS;
		end else begin
			return CHAR_SLASH;
		end
	endfunction

endpackage

`default_nettype wire

// ----- design/base64_encoder_line_wrapped.sv -----
// An accepted byte is held in the group register; each word it makes goes through the output register to m_tdata.
// Throughput: one output word per cycle while m_tready does not stall the output register; a byte makes
// 1 to 5 words (about 1.4 on average with padding and line feeds), sent by the single output serializer.
// A new byte is taken in the cycle its predecessor's last word moves to the output register.
// Reset (arst_n low, asynchronous): group phase, carried bits and column clear, line length 72.
`default_nettype none

module base64_encoder_line_wrapped import b64enc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration: line_chars
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	// input bytes
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // last_byte
	// output characters
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_char
	output logic [0:0]      m_tuser,   // [0] last_of_run
	output logic            m_tlast    // end_of_text
);

	logic [7:0] line_chars_q;
	phase_t     phase_q, phase_d;
	logic [3:0] carry_q, carry_d;

	group_t     grp_s1, grp_d;
	logic       valid_s1;

	logic [1:0] idx_q;
	logic       lf_q;
	logic       lf_end_q;
	logic [7:0] col_q;

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_run_q;
	logic       m_end_q;

	logic       accept;
	logic       advance;
	logic [7:0] eff;
	logic [8:0] col_inc;
	logic       need_lf;
	logic       is_last_char;
	logic       done;
	logic [7:0] out_char;
	logic       out_run;

	assign cfg_ready = 1'b1;

	// Hold the line length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_chars_q <= LINE_CHARS_RESET;
		end else if (cfg_valid) begin
			line_chars_q <= cfg_data;
		end
	end

	// Split the byte into the characters it completes
	always_comb begin
		grp_d          = '0;
		phase_d        = phase_q;
		carry_d        = carry_q;
		grp_d.msg_end  = s_tlast;
		case (phase_q)
			PH_1: begin
				grp_d.chars[0] = b64_char({carry_q[1:0], s_tdata[7:4]});
				if (s_tlast) begin
					grp_d.chars[1] = b64_char({s_tdata[3:0], 2'b00});
					grp_d.chars[2] = CHAR_PAD;
					grp_d.last_idx = 2'd2;
				end
				phase_d = PH_2;
				carry_d = s_tdata[3:0];
			end
			PH_2: begin
				grp_d.chars[0] = b64_char({carry_q, s_tdata[7:6]});
				grp_d.chars[1] = b64_char(s_tdata[5:0]);
				grp_d.last_idx = 2'd1;
				phase_d        = PH_0;
				carry_d        = 4'd0;
			end
			default: begin
				grp_d.chars[0] = b64_char(s_tdata[7:2]);
				if (s_tlast) begin
					grp_d.chars[1] = b64_char({s_tdata[1:0], 4'b0000});
					grp_d.chars[2] = CHAR_PAD;
					grp_d.chars[3] = CHAR_PAD;
					grp_d.last_idx = 2'd3;
				end
				phase_d = PH_1;
				carry_d = {2'b00, s_tdata[1:0]};
			end
		endcase
		if (s_tlast) begin
			phase_d = PH_0;
			carry_d = 4'd0;
		end
	end

	// Serializer: one character or line feed per advance
	always_comb begin
		eff          = (line_chars_q < MIN_LINE) ? MIN_LINE : line_chars_q;
		col_inc      = {1'b0, col_q} + 9'd1;
		need_lf      = (col_inc >= {1'b0, eff});
		is_last_char = (idx_q == grp_s1.last_idx);
		if (lf_q) begin
			out_char = CHAR_LF;
			out_run  = lf_end_q;
		end else begin
			out_char = grp_s1.chars[idx_q];
			out_run  = is_last_char && !need_lf;
		end
		advance  = valid_s1 && (!m_tvalid_q || m_tready);
		done     = advance && out_run;
		s_tready = !valid_s1 || done;
		accept   = s_tvalid && s_tready;
	end

	// Hold the group state and the group register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_0;
			carry_q  <= 4'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				carry_q <= carry_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grp_s1 <= grp_d;
		end
	end

	// Advance the character index, line feed flag and column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 2'd0;
			lf_q     <= 1'b0;
			lf_end_q <= 1'b0;
			col_q    <= 8'd0;
		end else if (advance) begin
			if (done) begin
				idx_q <= 2'd0;
				lf_q  <= 1'b0;
				if (grp_s1.msg_end) begin
					col_q <= 8'd0;
				end else if (!lf_q) begin
					col_q <= col_inc[7:0];
				end
			end else if (lf_q) begin
				lf_q <= 1'b0;
			end else begin
				if (need_lf) begin
					lf_q     <= 1'b1;
					lf_end_q <= is_last_char;
					col_q    <= 8'd0;
				end else begin
					col_q <= col_inc[7:0];
				end
				if (!is_last_char) begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= out_char;
			m_run_q   <= out_run;
			m_end_q   <= out_run && grp_s1.msg_end;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_run_q;
	assign m_tlast    = m_end_q;

endmodule

`default_nettype wire

// ----- design/b64enc_check.sv -----
`default_nettype none

module b64enc_check import b64enc_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [0:0] m_tuser,
	input wire logic       m_tlast
);

	logic legal_char;

	assign legal_char = (m_tdata >= 8'h41 && m_tdata <= 8'h5A) ||
		(m_tdata >= 8'h61 && m_tdata <= 8'h7A) ||
		(m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
		(m_tdata == CHAR_PLUS) || (m_tdata == CHAR_SLASH) ||
		(m_tdata == CHAR_PAD) || (m_tdata == CHAR_LF);

	// Stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
		&& $stable(m_tuser))
		else $error("stalled output word changed");

	// Message end closes the run of its byte
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("end of text without end of run");

	// Only alphabet, pad or line feed leaves the block
	a_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> legal_char)
		else $error("illegal output character");

	// A pad closing a run always ends the message
	a_pad_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata == CHAR_PAD && m_tuser[0] |-> m_tlast)
		else $error("final pad without end of text");

	// A line feed is never followed directly by another line feed
	a_no_double_lf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata == CHAR_LF ##1 m_tvalid
		|-> m_tdata != CHAR_LF)
		else $error("two line feeds in a row");

endmodule

bind base64_encoder_line_wrapped b64enc_check u_b64enc_check (.*);

`default_nettype wire
